FILE: sv/u8dec_pkg.sv
package u8dec_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ValueW = 21;
  localparam int unsigned StatW  = 2;
  localparam int unsigned LeftW  = 2;

  // Result status codes.
  localparam logic [StatW-1:0] ST_OK       = 2'd0;
  localparam logic [StatW-1:0] ST_BAD_LEAD = 2'd1;
  localparam logic [StatW-1:0] ST_BAD_CONT = 2'd2;
  localparam logic [StatW-1:0] ST_TRUNC    = 2'd3;

  // Depth of the result buffer: two entries of a circular queue.
  localparam int unsigned OutDepth = 2;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             end_of_data;
  } in_beat_t;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [StatW-1:0]  status;
  } out_beat_t;

endpackage

FILE: sv/u8dec_core.sv
// Sequence decoder: holds the partial value between bytes and produces at
// most one result for each byte it is given.
module u8dec_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  u8dec_pkg::in_beat_t  byte_in,
  output logic                 res_valid,
  output u8dec_pkg::out_beat_t res
);

  logic [u8dec_pkg::LeftW-1:0]  left_r, left_nxt;
  logic [u8dec_pkg::ValueW-1:0] acc_r, acc_nxt;
  logic                         cerr_r, cerr_nxt;

  logic [u8dec_pkg::ByteW-1:0]  x;
  logic                         last;
  logic [u8dec_pkg::ValueW-1:0] acc_shift;
  logic                         cerr_upd;
  logic [u8dec_pkg::LeftW-1:0]  left_dec;

  assign x         = byte_in.data_byte;
  assign last      = byte_in.end_of_data;
  assign acc_shift = {acc_r[u8dec_pkg::ValueW-7:0], x[5:0]};
  assign cerr_upd  = cerr_r | (x[7:6] != 2'b10);
  assign left_dec  = left_r - 2'd1;

  always_comb begin
    left_nxt   = left_r;
    acc_nxt    = acc_r;
    cerr_nxt   = cerr_r;
    res_valid  = 1'b0;
    res.value  = '0;
    res.status = u8dec_pkg::ST_OK;
    if (left_r == '0) begin
      if (!x[7]) begin
        res_valid = 1'b1;
        res.value = u8dec_pkg::ValueW'(x);
      end else if (x inside {[8'hC0:8'hF7]}) begin
        cerr_nxt = 1'b0;
        if (x inside {[8'hC0:8'hDF]}) begin
          acc_nxt  = u8dec_pkg::ValueW'(x[4:0]);
          left_nxt = 2'd1;
        end else if (x inside {[8'hE0:8'hEF]}) begin
          acc_nxt  = u8dec_pkg::ValueW'(x[3:0]);
          left_nxt = 2'd2;
        end else begin
          acc_nxt  = u8dec_pkg::ValueW'(x[2:0]);
          left_nxt = 2'd3;
        end
        if (last) begin
          left_nxt   = '0;
          acc_nxt    = '0;
          cerr_nxt   = 1'b0;
          res_valid  = 1'b1;
          res.status = u8dec_pkg::ST_TRUNC;
        end
      end else begin
        // A stray continuation byte or a 11111xxx byte cannot open a sequence.
        acc_nxt    = '0;
        cerr_nxt   = 1'b0;
        res_valid  = 1'b1;
        res.status = u8dec_pkg::ST_BAD_LEAD;
      end
    end else begin
      left_nxt = left_dec;
      acc_nxt  = acc_shift;
      cerr_nxt = cerr_upd;
      if (left_dec == '0) begin
        acc_nxt   = '0;
        cerr_nxt  = 1'b0;
        res_valid = 1'b1;
        if (cerr_upd) begin
          res.status = u8dec_pkg::ST_BAD_CONT;
        end else begin
          res.value = acc_shift;
        end
      end else if (last) begin
        left_nxt   = '0;
        acc_nxt    = '0;
        cerr_nxt   = 1'b0;
        res_valid  = 1'b1;
        res.status = u8dec_pkg::ST_TRUNC;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
      acc_r  <= '0;
      cerr_r <= 1'b0;
    end else if (step) begin
      left_r <= left_nxt;
      acc_r  <= acc_nxt;
      cerr_r <= cerr_nxt;
    end
  end

endmodule

FILE: sv/utf8_style_uint_decoder.sv
// Channel   Direction  Payload                          Handshake
// in_       input      data_byte[7:0], end_of_data      in_valid / in_stall
// out_      output     value[20:0], status[1:0]         out_valid / out_stall
//
// Each byte lands in the input register, is decoded from there and its
// result (if any) is written to the result buffer once the buffer has room.
// The sustained rate is one byte per clock while the result buffer has room,
// set by the single decode step between the two registers.
// Reset (rst_n low, synchronous) empties both stages and returns the decoder
// to expecting a lead byte.
// A stalled output is absorbed by a two-entry result buffer; in_stall rises
// only when the input register holds a byte and the buffer has no room.
module utf8_style_uint_decoder (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  u8dec_pkg::in_beat_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output u8dec_pkg::out_beat_t out_data
);

  localparam int unsigned CntW = $clog2(u8dec_pkg::OutDepth + 1);
  localparam int unsigned PtrW = $clog2(u8dec_pkg::OutDepth);

  // Input register.
  logic                s1_valid_r, s1_valid_nxt;
  u8dec_pkg::in_beat_t s1_data_r;

  // Result buffer: a small circular queue.
  u8dec_pkg::out_beat_t buf_r [u8dec_pkg::OutDepth];
  logic [CntW-1:0]      cnt_r, cnt_nxt;
  logic [PtrW-1:0]      wr_ptr_r, rd_ptr_r;

  logic                 in_take;
  logic                 out_pop;
  logic                 room;
  logic                 s1_adv;
  logic                 res_valid;
  u8dec_pkg::out_beat_t res;
  logic                 push;

  assign out_valid = (cnt_r != '0);
  assign out_data  = buf_r[rd_ptr_r];
  assign out_pop   = out_valid && !out_stall;

  // The decoder advances only when its possible result has a slot waiting.
  assign room     = (cnt_r < CntW'(u8dec_pkg::OutDepth)) || out_pop;
  assign s1_adv   = s1_valid_r && room;
  assign in_stall = s1_valid_r && !room;
  assign in_take  = in_valid && !in_stall;
  assign push     = s1_adv && res_valid;

  u8dec_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_adv),
    .byte_in   (s1_data_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !out_pop) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (!push && out_pop) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      cnt_r      <= '0;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      cnt_r      <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PtrW'(1);
      end
      if (out_pop) begin
        rd_ptr_r <= rd_ptr_r + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (push) begin
      buf_r[wr_ptr_r] <= res;
    end
  end

endmodule
